[sv/mntl_pkg.sv]
// Package for the MIDI note toggle latch: payload structs, command codes,
// queue entry type and shared constants. Depends on nothing.
package mntl_pkg;

  localparam int PAD_COUNT_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_W         = $clog2(MAX_RESULTS);
  localparam int Q_DEPTH       = 2;

  localparam logic [6:0] TRIG_BASE    = 7'd60;
  localparam logic [6:0] VEL_RESET    = 7'd100;
  localparam logic [3:0] NOTE_ON_HI   = 4'h9;
  localparam logic [3:0] NOTE_OFF_HI  = 4'h8;
  localparam logic [1:0] NOTE_BYTES   = 2'd3;
  localparam logic [4:0] CHAN_MAX     = 5'd16;

  typedef enum logic [1:0] {
    CMD_MIDI    = 2'd0,
    CMD_TOGGLE  = 2'd1,
    CMD_ALL_OFF = 2'd2,
    CMD_WRITE   = 2'd3
  } mntl_cmd_code_t;

  typedef enum logic [2:0] {
    K_PASS     = 3'd0,
    K_NOTE_ON  = 3'd1,
    K_NOTE_OFF = 3'd2,
    K_TOGGLE   = 3'd3,
    K_ALL_OFF  = 3'd4,
    K_WRITE    = 3'd5
  } mntl_kind_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] byte_count;
    logic [3:0] pad_index;
    logic [6:0] new_trigger;
    logic [6:0] new_output;
    logic [6:0] new_velocity;
    logic [4:0] new_channel;
  } mntl_in_t;

  typedef struct packed {
    logic [7:0] out_status;
    logic [6:0] out_data_one;
    logic [6:0] out_data_two;
    logic [1:0] out_count;
    logic       last_of_run;
  } mntl_out_t;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    mntl_kind_t kind;
    logic [3:0] pad;
    logic [6:0] note;
    logic [6:0] trig;
    logic [6:0] outn;
    logic [6:0] vel;
    logic [3:0] chan;
    mntl_out_t  pass;
  } mntl_cmd_t;

  function automatic mntl_out_t pad_msg(logic on, logic [3:0] chan, logic [6:0] note,
                                        logic [6:0] vel, logic last);
    mntl_out_t m;
    m.out_status   = {on ? NOTE_ON_HI : NOTE_OFF_HI, chan};
    m.out_data_one = note;
    m.out_data_two = vel;
    m.out_count    = NOTE_BYTES;
    m.last_of_run  = last;
    return m;
  endfunction

endpackage

[sv/midi_note_toggle_latch_unit.sv]
// Top level of the MIDI note toggle latch: front end, queue and back end.
// Depends on mntl_pkg, mntl_front, mntl_queue and mntl_back.
//
//   Channel   Direction   Payload      Handshake
//   in_       input       mntl_in_t    in_valid / in_ready
//   out_      output      mntl_out_t   out_valid / out_ready
//
// A pass-through message or a toggle command goes from the queue into the result
// register and from there, in ST_EMIT, into the output register; a note-on that has
// to be matched against the trigger notes first passes through ST_FIND, the compare
// across all pads. An all-pads-off command walks the latched pads in ST_SCAN instead.
// Reset is synchronous and active low; it restores every pad's default settings
// and clears the latches at once, with no clearing pass. The queue lets input
// beats keep arriving while the result register waits on out_ready.
module midi_note_toggle_latch_unit
  import mntl_pkg::*;
#(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mntl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mntl_out_t out_data
);

  // Classified items flow from the front end into the queue.
  logic      push_valid;
  logic      push_ready;
  mntl_cmd_t push_data;

  // And from the queue into the back end, which owns all pad state.
  logic      pop_valid;
  logic      pop_ready;
  mntl_cmd_t pop_data;

  // The front end needs no state of its own: it decodes the command, spots
  // note messages and discards commands aimed at a pad that does not exist.
  mntl_front #(
    .PAD_COUNT(PAD_COUNT)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  mntl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // The back end matches notes, flips latches, writes settings and walks the
  // latched pads for the all-off command, one note-off per beat.
  mntl_back #(
    .PAD_COUNT(PAD_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[sv/mntl_front.sv]
// Front end: accepts input beats and classifies them into queue entries.
// Depends on mntl_pkg.
module mntl_front
  import mntl_pkg::*;
#(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic      in_valid,
  output logic      in_ready,
  input  mntl_in_t  in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output mntl_cmd_t push_data
);

  logic       is_note;
  logic       is_on;
  logic       is_off;
  logic       idx_ok;
  logic       drop;
  logic [4:0] ch_clamp;

  always_comb begin
    is_note = (in_data.byte_count == NOTE_BYTES);
    is_on   = is_note && (in_data.status_byte[7:4] == NOTE_ON_HI) && (in_data.data_two != 7'd0);
    is_off  = is_note && ((in_data.status_byte[7:4] == NOTE_OFF_HI) ||
              ((in_data.status_byte[7:4] == NOTE_ON_HI) && (in_data.data_two == 7'd0)));
    idx_ok  = (32'(in_data.pad_index) < PAD_COUNT);

    if (in_data.new_channel == 5'd0) begin
      ch_clamp = 5'd1;
    end else if (in_data.new_channel > CHAN_MAX) begin
      ch_clamp = CHAN_MAX;
    end else begin
      ch_clamp = in_data.new_channel;
    end

    push_data.pad  = in_data.pad_index;
    push_data.note = in_data.data_one;
    push_data.trig = in_data.new_trigger;
    push_data.outn = in_data.new_output;
    push_data.vel  = (in_data.new_velocity == 7'd0) ? 7'd1 : in_data.new_velocity;
    push_data.chan = 4'(ch_clamp - 5'd1);

    // Data bytes beyond the byte count go out as zero.
    push_data.pass.out_status   = in_data.status_byte;
    push_data.pass.out_data_one = (in_data.byte_count >= 2'd2) ? in_data.data_one : 7'd0;
    push_data.pass.out_data_two = (in_data.byte_count == 2'd3) ? in_data.data_two : 7'd0;
    push_data.pass.out_count    = in_data.byte_count;
    push_data.pass.last_of_run  = 1'b1;

    drop = 1'b0;
    unique case (mntl_cmd_code_t'(in_data.command))
      CMD_MIDI: begin
        push_data.kind = is_on ? K_NOTE_ON : (is_off ? K_NOTE_OFF : K_PASS);
      end
      CMD_TOGGLE: begin
        push_data.kind = K_TOGGLE;
        drop = !idx_ok;
      end
      CMD_ALL_OFF: begin
        push_data.kind = K_ALL_OFF;
      end
      CMD_WRITE: begin
        push_data.kind = K_WRITE;
        drop = !idx_ok;
      end
      default: begin
        push_data.kind = K_PASS;
      end
    endcase
  end

  // Items without any effect are taken and discarded without entering the queue.
  assign in_ready   = push_ready;
  assign push_valid = in_valid && !drop;

endmodule

[sv/mntl_queue.sv]
// Short queue of classified items between the front and back ends.
// Depends on mntl_pkg.
module mntl_queue
  import mntl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  mntl_cmd_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output mntl_cmd_t pop_data
);

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  mntl_cmd_t         mem_r [Q_DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CW'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/mntl_back.sv]
// Back end: holds the pad settings and latches, carries out queued items and
// drives the registered result channel. Depends on mntl_pkg.
module mntl_back
  import mntl_pkg::*;
#(
  parameter int PAD_COUNT = PAD_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  mntl_cmd_t pop_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mntl_out_t out_data
);

  localparam int PW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FIND = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_SCAN = 4'b1000
  } mntl_state_t;

  mntl_state_t          state_r, state_nxt;
  logic [PAD_COUNT-1:0] latch_r, latch_nxt;
  logic [PAD_COUNT-1:0] mask_r, mask_nxt;
  logic [6:0]           trig_r [PAD_COUNT];
  logic [6:0]           outn_r [PAD_COUNT];
  logic [6:0]           vel_r  [PAD_COUNT];
  logic [3:0]           chan_r [PAD_COUNT];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  mntl_cmd_t            cur_r, cur_nxt;
  mntl_out_t            res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mntl_out_t            out_data_r, out_data_nxt;

  logic                 wr_en;
  logic [PW-1:0]        head_idx;
  logic [PW-1:0]        match_idx;
  logic                 match_hit;
  logic [PW-1:0]        low_idx;
  logic [PW-1:0]        rd_idx;
  logic [PAD_COUNT-1:0] mask_rest;
  logic                 out_free;
  logic                 scan_last;

  assign head_idx  = PW'(pop_data.pad);
  assign out_free  = !out_valid_r || out_ready;
  assign mask_rest = mask_r & (mask_r - PAD_COUNT'(1));
  assign scan_last = (mask_rest == '0) || (cnt_r == CNT_W'(MAX_RESULTS - 1));

  // Lowest pad whose trigger note matches, and lowest pad still to be reported.
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    low_idx   = '0;
    for (int i = PAD_COUNT - 1; i >= 0; i--) begin
      if (trig_r[i] == cur_r.note) begin
        match_hit = 1'b1;
        match_idx = PW'(i);
      end
      if (mask_r[i]) begin
        low_idx = PW'(i);
      end
    end
  end

  // One read port onto the pad settings, steered by the state.
  always_comb begin
    if (state_r == ST_FIND) begin
      rd_idx = match_idx;
    end else if (state_r == ST_SCAN) begin
      rd_idx = low_idx;
    end else begin
      rd_idx = head_idx;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    latch_nxt     = latch_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop_ready     = 1'b0;
    wr_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cur_nxt = pop_data;
          unique case (pop_data.kind) inside
            K_NOTE_ON, K_NOTE_OFF: begin
              state_nxt = ST_FIND;
            end
            K_TOGGLE: begin
              latch_nxt[rd_idx] = !latch_r[rd_idx];
              res_nxt   = pad_msg(!latch_r[rd_idx], chan_r[rd_idx], outn_r[rd_idx],
                                  vel_r[rd_idx], 1'b1);
              state_nxt = ST_EMIT;
            end
            K_ALL_OFF: begin
              mask_nxt  = latch_r;
              latch_nxt = '0;
              cnt_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            K_WRITE: begin
              wr_en = 1'b1;
              latch_nxt[head_idx] = 1'b0;
            end
            default: begin
              res_nxt   = pop_data.pass;
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_FIND: begin
        if (!match_hit) begin
          res_nxt   = cur_r.pass;
          state_nxt = ST_EMIT;
        end else if (cur_r.kind == K_NOTE_OFF) begin
          state_nxt = ST_IDLE;
        end else begin
          latch_nxt[rd_idx] = !latch_r[rd_idx];
          res_nxt   = pad_msg(!latch_r[rd_idx], chan_r[rd_idx], outn_r[rd_idx],
                              vel_r[rd_idx], 1'b1);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pad_msg(1'b0, chan_r[rd_idx], outn_r[rd_idx], vel_r[rd_idx],
                                  scan_last);
          mask_nxt      = mask_rest;
          cnt_nxt       = cnt_r + CNT_W'(1);
          if (scan_last) begin
            mask_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      latch_r     <= '0;
      mask_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PAD_COUNT; i++) begin
        trig_r[i] <= 7'(TRIG_BASE + 7'(i));
        outn_r[i] <= 7'(TRIG_BASE + 7'(i));
        vel_r[i]  <= VEL_RESET;
        chan_r[i] <= 4'd0;
      end
    end else begin
      state_r     <= state_nxt;
      latch_r     <= latch_nxt;
      mask_r      <= mask_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        trig_r[head_idx] <= pop_data.trig;
        outn_r[head_idx] <= pop_data.outn;
        vel_r[head_idx]  <= pop_data.vel;
        chan_r[head_idx] <= pop_data.chan;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[test/testbench.sv]
// Self-checking testbench for midi_note_toggle_latch_unit: a directed table and then random
// MIDI traffic and pad commands, with every result checked against a model of the pad bank or a pinned value.
// Depends on mntl_pkg and the unit itself.
module testbench
  import mntl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PADS           = PAD_COUNT_DEF;
  localparam int RANDOM_ITEMS   = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet spell after the last expected result, in which any further result counts as an error.
  localparam int DRAIN_CYCLES   = 40;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  mntl_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  mntl_out_t out_data;

  midi_note_toggle_latch_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 20 ns period; inputs move on the falling edge, outputs are sampled on the rising one.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Our own copy of the pad bank. Channels are held as channel minus one, as on the wire.
  bit         pad_on   [PADS];
  logic [6:0] pad_trig [PADS];
  logic [6:0] pad_outn [PADS];
  logic [6:0] pad_vel  [PADS];
  logic [3:0] pad_chan [PADS];

  // Messages the unit owes us, oldest first.
  mntl_out_t pending_msgs[$];

  int errors       = 0;
  int quiet_cycles = 0;
  // While set, neither side inserts gaps, so the unit runs back to back.
  bit steady       = 1'b0;

  typedef struct {
    mntl_in_t  beat;
    bit        fixed;
    mntl_out_t want;
  } stim_row_t;

  stim_row_t plan[$];

  function automatic mntl_out_t beat_out(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                         logic [1:0] cnt);
    mntl_out_t m;
    m.out_status   = st;
    m.out_data_one = d1;
    m.out_data_two = d2;
    m.out_count    = cnt;
    m.last_of_run  = 1'b1;
    return m;
  endfunction

  // A note message for pad p, reflecting whether its latch is now set.
  function automatic mntl_out_t pad_note(int p, logic last);
    mntl_out_t m;
    m.out_status   = {pad_on[p] ? NOTE_ON_HI : NOTE_OFF_HI, pad_chan[p]};
    m.out_data_one = pad_outn[p];
    m.out_data_two = pad_vel[p];
    m.out_count    = NOTE_BYTES;
    m.last_of_run  = last;
    return m;
  endfunction

  // Works out what one accepted beat does to the pad bank and which messages it causes.
  function automatic void latch_predict(mntl_in_t it);
    logic [3:0] hi;
    bit         is_on;
    bit         is_off;
    int         hit;
    int         i;
    int         total;
    int         k;
    int         vel;
    int         ch;
    hi = it.status_byte[7:4];
    case (it.command)
      CMD_MIDI: begin
        // Only a three-byte message counts as a note; the channel nibble is ignored.
        is_on  = it.byte_count == NOTE_BYTES && hi == NOTE_ON_HI && it.data_two != 0;
        is_off = it.byte_count == NOTE_BYTES &&
                 (hi == NOTE_OFF_HI || (hi == NOTE_ON_HI && it.data_two == 0));
        hit = -1;
        if (is_on || is_off) begin
          for (i = 0; i < PADS; i++) begin
            if (hit < 0 && pad_trig[i] == it.data_one) hit = i;
          end
        end
        if (hit >= 0) begin
          // A note-off on a mapped note is swallowed without a result.
          if (is_on) begin
            pad_on[hit] = !pad_on[hit];
            pending_msgs.push_back(pad_note(hit, 1'b1));
          end
        end else begin
          // Pass-through: data bytes beyond the count come out as zero.
          pending_msgs.push_back(beat_out(it.status_byte,
                                          it.byte_count >= 2 ? it.data_one : 7'd0,
                                          it.byte_count >= 3 ? it.data_two : 7'd0,
                                          it.byte_count));
        end
      end
      CMD_TOGGLE: begin
        pad_on[it.pad_index] = !pad_on[it.pad_index];
        pending_msgs.push_back(pad_note(it.pad_index, 1'b1));
      end
      CMD_ALL_OFF: begin
        total = 0;
        for (i = 0; i < PADS; i++) begin
          if (pad_on[i]) total++;
        end
        k = 0;
        for (i = 0; i < PADS; i++) begin
          if (pad_on[i]) begin
            pad_on[i] = 1'b0;
            k++;
            pending_msgs.push_back(pad_note(i, k == total));
          end
        end
      end
      default: begin
        // Pad write: clamp velocity and channel, clear the latch silently.
        vel = it.new_velocity;
        ch  = it.new_channel;
        if (vel < 1) vel = 1;
        if (ch < 1) ch = 1;
        if (ch > CHAN_MAX) ch = CHAN_MAX;
        pad_trig[it.pad_index] = it.new_trigger;
        pad_outn[it.pad_index] = it.new_output;
        pad_vel[it.pad_index]  = vel[6:0];
        pad_chan[it.pad_index] = 4'(ch - 1);
        pad_on[it.pad_index]   = 1'b0;
      end
    endcase
  endfunction

  function automatic mntl_in_t mk_midi(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                       logic [1:0] cnt);
    mntl_in_t b;
    b             = '0;
    b.command     = CMD_MIDI;
    b.status_byte = st;
    b.data_one    = d1;
    b.data_two    = d2;
    b.byte_count  = cnt;
    return b;
  endfunction

  function automatic mntl_in_t mk_toggle(logic [3:0] pad);
    mntl_in_t b;
    b           = '0;
    b.command   = CMD_TOGGLE;
    b.pad_index = pad;
    return b;
  endfunction

  function automatic mntl_in_t mk_all_off();
    mntl_in_t b;
    b         = '0;
    b.command = CMD_ALL_OFF;
    return b;
  endfunction

  function automatic mntl_in_t mk_write(logic [3:0] pad, logic [6:0] trig, logic [6:0] outn,
                                        logic [6:0] vel, logic [4:0] ch);
    mntl_in_t b;
    b              = '0;
    b.command      = CMD_WRITE;
    b.pad_index    = pad;
    b.new_trigger  = trig;
    b.new_output   = outn;
    b.new_velocity = vel;
    b.new_channel  = ch;
    return b;
  endfunction

  // Table rows: plain rows are checked against the model alone, pinned rows carry
  // a typed result that replaces what the model works out for that row.
  function automatic void plain(mntl_in_t b);
    stim_row_t r;
    r.beat  = b;
    r.fixed = 1'b0;
    r.want  = '0;
    plan.push_back(r);
  endfunction

  function automatic void pinned(mntl_in_t b, mntl_out_t want);
    stim_row_t r;
    r.beat  = b;
    r.fixed = 1'b1;
    r.want  = want;
    plan.push_back(r);
  endfunction

  // A beat with every field random; callers then shape the fields that matter.
  function automatic mntl_in_t rand_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(mntl_in_t)-1:0];
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one beat, holds it until the unit takes it, then updates the model.
  // Returns at the accepting edge, so the caller decides on the next falling edge.
  task automatic push_item(mntl_in_t b, bit fixed, mntl_out_t want);
    int gap;
    int before_n;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    before_n = pending_msgs.size();
    latch_predict(b);
    if (fixed) begin
      // The typed value replaces what the model worked out for this row.
      while (pending_msgs.size() > before_n) void'(pending_msgs.pop_back());
      pending_msgs.push_back(want);
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endfunction

  // Result side: random stalls, with runs of steady readiness in between.
  initial begin : receiver
    int left;
    left      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ready <= 1'b1;
      end else if (left > 0) begin
        left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        left = pick_gap();
      end else begin
        out_ready <= 1'b1;
        left = $urandom_range(0, 8);
      end
    end
  end

  // Every result beat is matched against the oldest expected message.
  always @(posedge clk) begin : monitor
    mntl_out_t want;
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (pending_msgs.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: result 0x%0h arrived with nothing expected", $realtime, out_data);
      end else begin
        want = pending_msgs.pop_front();
        check_field("out_status",   want.out_status,   out_data.out_status);
        check_field("out_data_one", want.out_data_one, out_data.out_data_one);
        check_field("out_data_two", want.out_data_two, out_data.out_data_two);
        check_field("out_count",    want.out_count,    out_data.out_count);
        check_field("last_of_run",  want.last_of_run,  out_data.last_of_run);
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    mntl_in_t b;
    int       sent;
    int       pick;
    int       p;
    bit       drained;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (p = 0; p < PADS; p++) begin
      pad_on[p]   = 1'b0;
      pad_trig[p] = TRIG_BASE + 7'(p);
      pad_outn[p] = TRIG_BASE + 7'(p);
      pad_vel[p]  = VEL_RESET;
      pad_chan[p] = 4'd0;
    end

    // Directed part. Pads start out triggered and sounding on note 60 + pad, velocity
    // 100, channel one.
    pinned(mk_midi(8'h90, 60, 127, 3), beat_out(8'h90, 60, 100, 3));
    // The channel nibble of the incoming status is not compared.
    pinned(mk_midi(8'h9F, 60, 1, 3), beat_out(8'h80, 60, 100, 3));
    pinned(mk_midi(8'h93, 75, 1, 3), beat_out(8'h90, 75, 100, 3));
    // Note-off, and note-on with zero velocity, on mapped notes are swallowed.
    plain(mk_midi(8'h80, 75, 127, 3));
    plain(mk_midi(8'h9A, 61, 0, 3));
    // Notes that no pad listens to go straight through.
    pinned(mk_midi(8'h90, 0, 127, 3), beat_out(8'h90, 0, 127, 3));
    pinned(mk_midi(8'h8F, 127, 127, 3), beat_out(8'h8F, 127, 127, 3));
    // Short messages are never notes, and bytes beyond the count come out as zero.
    pinned(mk_midi(8'h90, 60, 50, 2), beat_out(8'h90, 60, 0, 2));
    pinned(mk_midi(8'hF8, 5, 9, 1), beat_out(8'hF8, 0, 0, 1));
    pinned(mk_midi(8'h00, 127, 127, 0), beat_out(8'h00, 0, 0, 0));
    pinned(mk_midi(8'hFF, 127, 127, 3), beat_out(8'hFF, 127, 127, 3));
    pinned(mk_toggle(0), beat_out(8'h90, 60, 100, 3));
    pinned(mk_toggle(15), beat_out(8'h80, 75, 100, 3));
    pinned(mk_toggle(3), beat_out(8'h90, 63, 100, 3));
    // Velocity and channel of zero are clamped up to one.
    plain(mk_write(5, 0, 127, 0, 0));
    pinned(mk_midi(8'h90, 0, 64, 3), beat_out(8'h90, 127, 1, 3));
    // Channels above sixteen are clamped to sixteen.
    plain(mk_write(6, 127, 0, 127, 31));
    pinned(mk_midi(8'h91, 127, 127, 3), beat_out(8'h9F, 0, 127, 3));
    // Two pads share a trigger note: the lower one wins.
    plain(mk_write(7, 127, 1, 64, 16));
    pinned(mk_midi(8'h90, 127, 5, 3), beat_out(8'h8F, 0, 127, 3));
    // Rewriting a latched pad clears it without a note-off.
    plain(mk_write(5, 5, 5, 127, 1));
    plain(mk_all_off());
    // All-off with nothing latched says nothing.
    plain(mk_all_off());
    pinned(mk_midi(8'h90, 0, 100, 3), beat_out(8'h90, 0, 100, 3));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) push_item(plan[k].beat, plan[k].fixed, plan[k].want);

    // Random part: note-ons that hit a pad, the largest share, so latches keep flipping,
    // with commands, swallowed note-offs and raw traffic mixed in.
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      steady = sent >= 60 && sent < 100;
      if (!drained && sent >= 130) begin
        // Hold off the sender until the unit has delivered everything it owes.
        drained = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge clk);
      end
      b    = rand_beat();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // Latch every pad, then release them all: the longest all-off run.
        for (p = 0; p < PADS; p++) begin
          if (!pad_on[p]) push_item(mk_toggle(p), 1'b0, '0);
        end
        push_item(mk_all_off(), 1'b0, '0);
        sent += PADS + 1;
      end else begin
        if (pick < 40) begin
          b.command     = CMD_MIDI;
          b.status_byte = {NOTE_ON_HI, b.status_byte[3:0]};
          b.data_one    = pad_trig[$urandom_range(0, PADS - 1)];
          b.data_two    = $urandom_range(1, 127);
          b.byte_count  = NOTE_BYTES;
        end else if (pick < 50) begin
          b.command     = CMD_MIDI;
          b.data_one    = pad_trig[$urandom_range(0, PADS - 1)];
          b.byte_count  = NOTE_BYTES;
          if (b.status_byte[0]) begin
            b.status_byte = {NOTE_OFF_HI, b.status_byte[3:0]};
          end else begin
            b.status_byte = {NOTE_ON_HI, b.status_byte[3:0]};
            b.data_two    = 7'd0;
          end
        end else if (pick < 64) begin
          b.command = CMD_TOGGLE;
        end else if (pick < 71) begin
          b.command = CMD_ALL_OFF;
        end else if (pick < 80) begin
          b.command = CMD_WRITE;
          // Keep most triggers on the default range so that pads overlap.
          if ($urandom_range(0, 9) < 7) b.new_trigger = TRIG_BASE + 7'($urandom_range(0, 15));
        end else begin
          b.command = CMD_MIDI;
        end
        push_item(b, 1'b0, '0);
        sent++;
      end
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_msgs.size() != 0) errors++;

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
sv/mntl_pkg.sv
sv/mntl_front.sv
sv/mntl_queue.sv
sv/mntl_back.sv
sv/midi_note_toggle_latch_unit.sv
test/testbench.sv
